// ===== rtl/multi_slot_timer_manager_assert.svh =====
// Assertion macros used by the timer manager top level.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef MULTI_SLOT_TIMER_MANAGER_ASSERT_SVH
`define MULTI_SLOT_TIMER_MANAGER_ASSERT_SVH

// same-cycle implication
`define MSTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mstm_pkg.sv =====
// Types, codes and expiry arithmetic for the multi-slot timer manager.
// No dependencies.
package mstm_pkg;

  localparam int unsigned MAX_OUT = 16;

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_RESET  = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_NOTACT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic        active;
    logic        periodic;
    logic [22:0] per_sec;   // period / 1000
    logic [19:0] per_usec;  // (period % 1000) * 1000
    logic [32:0] exp_sec;
    logic [19:0] exp_usec;
  } slot_rec_t;

  typedef struct packed {
    logic [32:0] sec;
    logic [19:0] usec;
  } expiry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic        fired;
    logic [41:0] timeout_ms;
    logic        timeout_valid;
    logic        last;
  } rsp_t;

  function automatic expiry_t arm_expiry(input logic [32:0] bs, input logic [19:0] bu,
                                         input logic [22:0] ps, input logic [19:0] pu);
    logic [20:0] u;
    logic [32:0] s;
    expiry_t     e;
    u = {1'b0, bu} + {1'b0, pu};
    s = bs + 33'(ps);
    if (u >= 21'd2000000) begin
      s = s + 33'd2;
      u = u - 21'd2000000;
    end else if (u >= 21'd1000000) begin
      s = s + 33'd1;
      u = u - 21'd1000000;
    end
    e.sec  = s;
    e.usec = u[19:0];
    return e;
  endfunction

endpackage

// ===== rtl/mstm_cmd_if.sv =====
// Command channel of the timer manager: valid/ready plus the item fields.
// Depends on nothing.
interface mstm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [31:0] now_sec;
  logic [19:0] now_usec;
  logic [31:0] period_ms;
  logic        periodic;

  modport source (output valid, kind, slot, now_sec, now_usec, period_ms, periodic,
                  input ready);
  modport sink (input valid, kind, slot, now_sec, now_usec, period_ms, periodic,
                output ready);
endinterface

// ===== rtl/mstm_rsp_if.sv =====
// Result channel of the timer manager: valid/ready plus the result fields.
// Depends on nothing.
interface mstm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  result_slot;
  logic        fired;
  logic [41:0] timeout_ms;
  logic        timeout_valid;
  logic        last;

  modport source (output valid, status, result_slot, fired, timeout_ms, timeout_valid, last,
                  input ready);
  modport sink (input valid, status, result_slot, fired, timeout_ms, timeout_valid, last,
                output ready);
endinterface

// ===== rtl/mstm_cell.sv =====
// One timer slot of the rotating slot ring.
// Depends on mstm_pkg.
module mstm_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  mstm_pkg::slot_rec_t d,
  output mstm_pkg::slot_rec_t q
);
  import mstm_pkg::*;

  logic      active;
  slot_rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (shift) begin
      active <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= d;
    end
  end

  always_comb begin
    q        = rec;
    q.active = active;
  end
endmodule

// ===== rtl/mstm_div.sv =====
// Divide by 1000 of the create period by reciprocal multiplication: product, then quotient, then remainder.
// Depends on nothing.
module mstm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  output logic        busy,
  output logic [22:0] quot,
  output logic [9:0]  rem
);
  logic [31:0] num;
  logic [60:0] prod;
  logic [1:0]  phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 2'd0;
    end else if (busy) begin
      phase <= phase + 2'd1;
      if (phase == 2'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // ceil(2^38 / 1000) gives the exact truncated quotient for any 32-bit dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      prod <= 61'(dividend) * 61'd274877907;
    end
    if (busy && phase == 2'd0) begin
      quot <= prod[60:38];
    end
    // rem = num - quot * (1024 - 16 - 8)
    if (busy && phase == 2'd1) begin
      rem <= 10'(num - ((32'(quot) << 10) - (32'(quot) << 4) - (32'(quot) << 3)));
    end
  end
endmodule

// ===== rtl/mstm_qry.sv =====
// Pipelined time-to-expiry and running minimum for the query scan.
// Depends on mstm_pkg.
module mstm_qry (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                vld,
  input  mstm_pkg::slot_rec_t rec,
  input  logic [31:0]         now_sec,
  input  logic [19:0]         now_usec,
  output logic                got,
  output logic signed [45:0]  best
);
  import mstm_pkg::*;

  logic               s1_v, s2_v, s3_v;
  logic signed [34:0] s1_sd;
  logic signed [20:0] s1_ud;
  logic signed [44:0] s2_sdk;
  logic               s2_neg;
  logic [10:0]        s2_uq;
  logic signed [45:0] s3_m;
  logic signed [44:0] sdx;
  logic [19:0]        umag;
  logic [48:0]        uprod;

  assign sdx   = 45'(s1_sd);
  assign umag  = s1_ud[20] ? 20'(-s1_ud) : s1_ud[19:0];
  // exact truncating divide by 1000 for operands below 2^32
  assign uprod = 49'(umag) * 49'd274877907;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      got  <= 1'b0;
    end else begin
      s1_v <= vld;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (clear) begin
        got <= 1'b0;
      end else if (s3_v && (!got || s3_m < best)) begin
        got <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_sd  <= $signed({2'b00, rec.exp_sec}) - $signed({3'b000, now_sec});
    s1_ud  <= $signed({1'b0, rec.exp_usec}) - $signed({1'b0, now_usec});
    s2_sdk <= (sdx <<< 10) - (sdx <<< 5) + (sdx <<< 3);
    s2_neg <= s1_ud[20];
    s2_uq  <= uprod[48:38];
    s3_m   <= 46'(s2_sdk) + (s2_neg ? -$signed({35'd0, s2_uq}) : $signed({35'd0, s2_uq}));
    if (s3_v && (!got || s3_m < best)) begin
      best <= s3_m;
    end
  end
endmodule

// ===== rtl/multi_slot_timer_manager.sv =====
// Channel   Dir  Handshake        Payload
// cmd       in   valid/ready      kind, slot, now_sec, now_usec, period_ms, periodic
// rsp       out  valid/ready      status, result_slot, fired, timeout_ms, timeout_valid, last
// apb       in   psel/penable     floor_timeout_ms at address 0
//
// Each command of a known kind rotates the slot ring once, then drains the query
// pipeline and posts the result. A create first runs the divide by 1000; an unknown kind skips the ring.
// A tick stalls the ring when a due slot would fire while an earlier fired result waits on a busy rsp register.
// Synchronous reset clears the active flag of every slot at once; no clearing pass.
// Depends on mstm_pkg, mstm_cmd_if, mstm_rsp_if, mstm_cell, mstm_div, mstm_qry.
`include "multi_slot_timer_manager_assert.svh"

module multi_slot_timer_manager #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  mstm_cmd_if.sink    cmd,
  mstm_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mstm_pkg::*;

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = (IW > 4) ? IW : 4;
  localparam int unsigned FW = $clog2(MAX_OUT + 1);

  state_t      state, state_next;
  logic [15:0] floor_ms;

  logic [2:0]  cur_kind;
  logic [3:0]  cur_slot;
  logic [31:0] cur_sec;
  logic [19:0] cur_usec;
  logic        cur_periodic;

  logic [IW-1:0] idx;
  logic [1:0]    drain_cnt;
  logic [FW-1:0] fire_cnt;
  logic          done;
  logic [3:0]    done_slot;
  logic          pend_v;
  logic [3:0]    pend_slot;
  logic          out_v;
  rsp_t          out_r;

  slot_rec_t cell_q [NUM_TIMERS];
  slot_rec_t new_head, head;
  logic      step, fire, hit, out_free, accept, wr_en;
  expiry_t   arm_now, arm_reload, arm_create;
  logic      due;
  logic [32:0] now_x;

  logic        div_busy;
  logic [22:0] div_quot;
  logic [9:0]  div_rem;
  logic [19:0] rem_us;

  logic              q_got;
  logic signed [45:0] q_best;
  logic [41:0]       tmo;
  rsp_t              fin_rsp;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, floor_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_ms <= 16'd500;
    end else if (wr_en) begin
      floor_ms <= pwdata[15:0];
    end
  end

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_v || rsp.ready;

  mstm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && cmd.kind == KIND_CREATE),
    .dividend (cmd.period_ms),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // rem * 1000 = rem * (1024 - 16 - 8)
  assign rem_us = ({10'd0, div_rem} << 10) - ({10'd0, div_rem} << 4)
                - ({10'd0, div_rem} << 3);

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ring
    slot_rec_t d_in;
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign d_in = new_head;
    end else begin : g_mid
      assign d_in = cell_q[i+1];
    end
    mstm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d     (d_in),
      .q     (cell_q[i])
    );
  end

  assign head       = cell_q[0];
  assign now_x      = {1'b0, cur_sec};
  assign due        = (head.exp_sec < now_x)
                   || (head.exp_sec == now_x && head.exp_usec <= cur_usec);
  assign hit        = (CW'(idx) == CW'(cur_slot)) && head.active;
  assign arm_now    = arm_expiry(now_x, cur_usec, head.per_sec, head.per_usec);
  assign arm_reload = arm_expiry(head.exp_sec, head.exp_usec, head.per_sec, head.per_usec);
  assign arm_create = arm_expiry(now_x, cur_usec, div_quot, rem_us);

  // work on the slot at the head of the ring
  always_comb begin
    new_head = head;
    step     = 1'b0;
    fire     = 1'b0;
    if (state == ST_SCAN) begin
      step = 1'b1;
      case (cur_kind)
        KIND_CREATE: begin
          if (!done && !head.active) begin
            new_head.active   = 1'b1;
            new_head.periodic = cur_periodic;
            new_head.per_sec  = div_quot;
            new_head.per_usec = rem_us;
            new_head.exp_sec  = arm_create.sec;
            new_head.exp_usec = arm_create.usec;
          end
        end
        KIND_CANCEL: begin
          if (hit) begin
            new_head.active = 1'b0;
          end
        end
        KIND_RESET: begin
          if (hit) begin
            new_head.exp_sec  = arm_now.sec;
            new_head.exp_usec = arm_now.usec;
          end
        end
        KIND_TICK: begin
          if (head.active && due && fire_cnt < FW'(MAX_OUT)) begin
            if (pend_v && !out_free) begin
              step = 1'b0;   // hold the ring until the earlier result moves on
            end else begin
              fire = 1'b1;
              if (head.periodic) begin
                new_head.exp_sec  = arm_reload.sec;
                new_head.exp_usec = arm_reload.usec;
              end else begin
                new_head.active = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  mstm_qry u_qry (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept),
    .vld      (step && cur_kind == KIND_QUERY && head.active),
    .rec      (head),
    .now_sec  (cur_sec),
    .now_usec (cur_usec),
    .got      (q_got),
    .best     (q_best)
  );

  always_comb begin
    if (q_best <= 46'sd0) begin
      tmo = {26'd0, floor_ms};
    end else if (q_best > 46'sh3FFFFFFFFFF) begin
      tmo = '1;
    end else begin
      tmo = q_best[41:0];
    end
  end

  always_comb begin
    fin_rsp      = '0;
    fin_rsp.last = 1'b1;
    case (cur_kind)
      KIND_CREATE: begin
        fin_rsp.status      = done ? STAT_OK : STAT_NOFREE;
        fin_rsp.result_slot = done ? done_slot : 4'd0;
      end
      KIND_CANCEL, KIND_RESET: begin
        fin_rsp.status      = done ? STAT_OK : STAT_NOTACT;
        fin_rsp.result_slot = cur_slot;
      end
      KIND_TICK: begin
        fin_rsp.result_slot = pend_v ? pend_slot : 4'd0;
        fin_rsp.fired       = pend_v;
      end
      KIND_QUERY: begin
        fin_rsp.timeout_ms    = q_got ? tmo : 42'd0;
        fin_rsp.timeout_valid = q_got;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.kind == KIND_CREATE) begin
            state_next = ST_DIV;
          end else if (cmd.kind == KIND_CANCEL || cmd.kind == KIND_RESET
                       || cmd.kind == KIND_TICK || cmd.kind == KIND_QUERY) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && idx == IW'(NUM_TIMERS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'd2) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_kind     <= cmd.kind;
      cur_slot     <= cmd.slot;
      cur_sec      <= cmd.now_sec;
      cur_usec     <= cmd.now_usec;
      cur_periodic <= cmd.periodic;
    end
    if (step && !done && (cur_kind == KIND_CREATE) && !head.active) begin
      done_slot <= 4'(idx);
    end
    if (fire) begin
      pend_slot <= 4'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      drain_cnt <= 2'd0;
      fire_cnt  <= '0;
      done      <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (accept) begin
        idx       <= '0;
        drain_cnt <= 2'd0;
        fire_cnt  <= '0;
        done      <= 1'b0;
        pend_v    <= 1'b0;
      end else begin
        if (step) begin
          idx <= (idx == IW'(NUM_TIMERS - 1)) ? '0 : idx + 1'b1;
          if ((cur_kind == KIND_CREATE && !head.active)
              || ((cur_kind == KIND_CANCEL || cur_kind == KIND_RESET) && hit)) begin
            done <= 1'b1;
          end
        end
        if (state == ST_DRAIN) begin
          drain_cnt <= drain_cnt + 2'd1;
        end
        if (fire) begin
          fire_cnt <= fire_cnt + 1'b1;
          pend_v   <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire && pend_v) begin
      out_v <= 1'b1;
    end else if (state == ST_FIN && out_free) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pend_v) begin
      out_r             <= '0;
      out_r.result_slot <= pend_slot;
      out_r.fired       <= 1'b1;
    end else if (state == ST_FIN && out_free) begin
      out_r <= fin_rsp;
    end
  end

  assign rsp.valid         = out_v;
  assign rsp.status        = out_r.status;
  assign rsp.result_slot   = out_r.result_slot;
  assign rsp.fired         = out_r.fired;
  assign rsp.timeout_ms    = out_r.timeout_ms;
  assign rsp.timeout_valid = out_r.timeout_valid;
  assign rsp.last          = out_r.last;

  `MSTM_ASSERT_IMP(a_fire_cap, 1'b1, fire_cnt <= FW'(MAX_OUT), "fire count above cap")
  `MSTM_ASSERT_IMP(a_pend_tick, pend_v, cur_kind == KIND_TICK, "pending fire outside tick")
  `MSTM_ASSERT_NXT(a_fin_done, state == ST_FIN && out_free, state == ST_IDLE && out_v,
                   "final result not posted")
  `MSTM_ASSERT_IMP(a_fire_scan, fire, state == ST_SCAN && step, "fire outside ring step")
endmodule

// ===== sim/tb_multi_slot_timer_manager.sv =====
// Self-checking testbench for multi_slot_timer_manager: random and directed timer commands,
// a built-in slot model predicting every result, random stalls on both channels.
// Depends on mstm_pkg, mstm_cmd_if, mstm_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module tb_multi_slot_timer_manager;
  import mstm_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [2:0] KIND_BAD_LO = 3'd5;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;
  localparam logic [2:0] FLOOR_ADDR = 3'd0;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
    logic [31:0] period_ms;
    logic        periodic;
  } timer_cmd_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mstm_cmd_if cmd ();
  mstm_rsp_if rsp ();

  multi_slot_timer_manager dut (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // slot model
  logic        tmr_active   [SLOTS];
  logic        tmr_periodic [SLOTS];
  logic [31:0] tmr_period   [SLOTS];
  logic [32:0] tmr_exp_sec  [SLOTS];
  logic [19:0] tmr_exp_usec [SLOTS];
  logic [15:0] floor_ms;

  timer_cmd_t cmd_backlog[$];
  rsp_t       timer_events_q[$];
  int unsigned mismatches;
  bit          burst_mode;
  int unsigned send_gap, rsp_stall;
  bit          cmd_fire, rsp_fire;

  function automatic void rearm(int s, logic [32:0] bs, logic [19:0] bu);
    longint unsigned sec;
    longint unsigned usec;
    sec  = {31'd0, bs} + tmr_period[s] / 1000;
    usec = bu + (tmr_period[s] % 1000) * 1000;
    if (usec >= 1000000) begin
      sec  = sec + usec / 1000000;
      usec = usec % 1000000;
    end
    tmr_exp_sec[s]  = sec[32:0];
    tmr_exp_usec[s] = usec[19:0];
  endfunction

  function automatic rsp_t make_rsp(logic [1:0] st, logic [3:0] sl, logic f,
                                    logic [41:0] tmo, logic tv, logic l);
    rsp_t r;
    r.status = st; r.result_slot = sl; r.fired = f;
    r.timeout_ms = tmo; r.timeout_valid = tv; r.last = l;
    return r;
  endfunction

  function automatic void predict_timer_op(timer_cmd_t c);
    int     k;
    bit     got;
    longint best, m;
    k = 0;
    got = 0;
    best = 0;
    case (c.kind)
      KIND_CREATE: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!tmr_active[s] && !got) begin
            got = 1;
            tmr_active[s]   = 1;
            tmr_periodic[s] = c.periodic;
            tmr_period[s]   = c.period_ms;
            rearm(s, {1'b0, c.now_sec}, c.now_usec);
            timer_events_q.push_back(make_rsp(STAT_OK, 4'(s), 0, 0, 0, 1));
          end
        end
        if (!got) timer_events_q.push_back(make_rsp(STAT_NOFREE, 0, 0, 0, 0, 1));
      end
      KIND_CANCEL, KIND_RESET: begin
        if (!tmr_active[c.slot]) begin
          timer_events_q.push_back(make_rsp(STAT_NOTACT, c.slot, 0, 0, 0, 1));
        end else begin
          if (c.kind == KIND_CANCEL) tmr_active[c.slot] = 0;
          else rearm(c.slot, {1'b0, c.now_sec}, c.now_usec);
          timer_events_q.push_back(make_rsp(STAT_OK, c.slot, 0, 0, 0, 1));
        end
      end
      KIND_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tmr_active[s] && (tmr_exp_sec[s] < {1'b0, c.now_sec} ||
              (tmr_exp_sec[s] == {1'b0, c.now_sec} && tmr_exp_usec[s] <= c.now_usec))) begin
            timer_events_q.push_back(make_rsp(STAT_OK, 4'(s), 1, 0, 0, 0));
            k++;
            if (tmr_periodic[s]) rearm(s, tmr_exp_sec[s], tmr_exp_usec[s]);
            else tmr_active[s] = 0;
          end
        end
        if (k == 0) timer_events_q.push_back(make_rsp(STAT_OK, 0, 0, 0, 0, 1));
        else timer_events_q[$].last = 1;
      end
      KIND_QUERY: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tmr_active[s]) begin
            m = (longint'({31'd0, tmr_exp_sec[s]}) - longint'({32'd0, c.now_sec})) * 1000
                + (longint'({44'd0, tmr_exp_usec[s]}) - longint'({44'd0, c.now_usec})) / 1000;
            if (!got || m < best) best = m;
            got = 1;
          end
        end
        if (!got) timer_events_q.push_back(make_rsp(STAT_OK, 0, 0, 0, 0, 1));
        else if (best <= 0) timer_events_q.push_back(make_rsp(STAT_OK, 0, 0, 42'(floor_ms), 1, 1));
        else if (best > 64'h3FF_FFFF_FFFF)
          timer_events_q.push_back(make_rsp(STAT_OK, 0, 0, 42'h3FF_FFFF_FFFF, 1, 1));
        else timer_events_q.push_back(make_rsp(STAT_OK, 0, 0, best[41:0], 1, 1));
      end
      default: timer_events_q.push_back(make_rsp(STAT_OK, 0, 0, 0, 0, 1));
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // prediction on command transfer, checking on result transfer
  always @(posedge clk) begin
    timer_cmd_t c;
    rsp_t       want;
    cmd_fire <= !rst && cmd.valid && cmd.ready;
    rsp_fire <= !rst && rsp.valid && rsp.ready;
    if (!rst && cmd.valid && cmd.ready) begin
      c.kind = cmd.kind; c.slot = cmd.slot; c.now_sec = cmd.now_sec;
      c.now_usec = cmd.now_usec; c.period_ms = cmd.period_ms; c.periodic = cmd.periodic;
      predict_timer_op(c);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (timer_events_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: slot %0d fired %0b", rsp.result_slot, rsp.fired);
      end else begin
        want = timer_events_q.pop_front();
        if (rsp.status !== want.status || rsp.result_slot !== want.result_slot ||
            rsp.fired !== want.fired || rsp.timeout_ms !== want.timeout_ms ||
            rsp.timeout_valid !== want.timeout_valid || rsp.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp st=%0d sl=%0d f=%0b tmo=%0d tv=%0b l=%0b, got st=%0d sl=%0d f=%0b tmo=%0d tv=%0b l=%0b",
                     want.status, want.result_slot, want.fired, want.timeout_ms,
                     want.timeout_valid, want.last, rsp.status, rsp.result_slot,
                     rsp.fired, rsp.timeout_ms, rsp.timeout_valid, rsp.last);
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    timer_cmd_t c;
    if (!rst && !(cmd.valid && !cmd_fire)) begin
      if (send_gap > 0) begin
        cmd.valid = 0;
        send_gap--;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        cmd.kind = c.kind; cmd.slot = c.slot; cmd.now_sec = c.now_sec;
        cmd.now_usec = c.now_usec; cmd.period_ms = c.period_ms; cmd.periodic = c.periodic;
        cmd.valid = 1;
        send_gap = burst_mode ? 0 : $urandom_range(0, 13);
      end else begin
        cmd.valid = 0;
      end
    end
  end

  // result stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_fire) rsp_stall = burst_mode ? 0 : $urandom_range(0, 13);
      if (rsp_stall > 0) begin
        rsp.ready = 0;
        rsp_stall--;
      end else begin
        rsp.ready = 1;
      end
    end
  end

  task automatic push_cmd(logic [2:0] k, logic [3:0] sl, logic [31:0] s, logic [19:0] u,
                          logic [31:0] p, logic per);
    timer_cmd_t c;
    c.kind = k; c.slot = sl; c.now_sec = s; c.now_usec = u; c.period_ms = p; c.periodic = per;
    cmd_backlog.push_back(c);
  endtask

  task automatic drain_all();
    while (cmd_backlog.size() > 0 || cmd.valid || timer_events_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_floor(logic [31:0] v);
    @(negedge clk);
    psel = 1; pwrite = 1; paddr = FLOOR_ADDR; pwdata = v; penable = 0;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    floor_ms = v[15:0];
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  initial begin
    logic [31:0] base_sec;
    logic [19:0] base_usec;
    int unsigned r, step_ms;
    logic [31:0] per;
    logic [31:0] phase_floor [4];
    cmd.valid = 0; cmd.kind = 0; cmd.slot = 0; cmd.now_sec = 0; cmd.now_usec = 0;
    cmd.period_ms = 0; cmd.periodic = 0;
    rsp.ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    mismatches = 0; send_gap = 0; rsp_stall = 0; burst_mode = 0;
    floor_ms = 16'd500;
    for (int s = 0; s < SLOTS; s++) tmr_active[s] = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty table, edge fields, full table, unknown kinds
    push_cmd(KIND_QUERY, 0, 32'd100, 0, 0, 0);
    push_cmd(KIND_TICK, 0, 32'd100, 0, 0, 0);
    push_cmd(KIND_CANCEL, 4'd15, 0, 0, 0, 0);
    push_cmd(KIND_RESET, 4'd3, 0, 0, 0, 0);
    push_cmd(KIND_BAD_LO, 4'hF, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 1);
    push_cmd(KIND_BAD_HI, 0, 0, 0, 0, 0);
    push_cmd(KIND_CREATE, 0, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF, 0);
    push_cmd(KIND_QUERY, 0, 32'd0, 20'd0, 0, 0);
    push_cmd(KIND_CANCEL, 4'd0, 0, 0, 0, 0);
    for (int s = 0; s < SLOTS; s++) push_cmd(KIND_CREATE, 0, 32'd50, 20'd999999, 0, s[0]);
    push_cmd(KIND_CREATE, 0, 32'd50, 0, 32'd10, 1);
    push_cmd(KIND_QUERY, 0, 32'd51, 0, 0, 0);
    push_cmd(KIND_TICK, 0, 32'd51, 0, 0, 0);
    push_cmd(KIND_RESET, 4'd1, 32'd60, 20'd999999, 0, 0);
    push_cmd(KIND_TICK, 0, 32'd61, 0, 0, 0);
    drain_all();
    for (int s = 0; s < SLOTS; s += 2) push_cmd(KIND_CANCEL, 4'(s + 1), 0, 0, 0, 0);
    drain_all();

    phase_floor[0] = 32'd0;
    phase_floor[1] = 32'hFFFF_FFFF;
    phase_floor[2] = $urandom;
    phase_floor[3] = 32'd1;
    for (int ph = 0; ph < 4; ph++) begin
      write_floor(phase_floor[ph]);
      base_sec  = (ph == 1) ? 32'hFFFF_0000 + $urandom_range(0, 255) : $urandom;
      base_usec = $urandom_range(0, 999999);
      for (int n = 0; n < 120; n++) begin
        burst_mode = (n >= 40 && n < 60);
        step_ms = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60000) : $urandom_range(0, 1500);
        base_sec  = base_sec + step_ms / 1000 + (base_usec + (step_ms % 1000) * 1000) / 1000000;
        base_usec = (base_usec + (step_ms % 1000) * 1000) % 1000000;
        per = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3000);
        r = $urandom_range(0, 99);
        if (r < 8)  // noise: arbitrary time, possibly out-of-range microseconds
          push_cmd(3'($urandom_range(0, 7)), 4'($urandom), $urandom, 20'($urandom),
                   $urandom, 1'($urandom));
        else if (r < 35)
          push_cmd(KIND_CREATE, 4'($urandom), base_sec, base_usec, per, 1'($urandom));
        else if (r < 45)
          push_cmd(KIND_CANCEL, 4'($urandom), base_sec, base_usec, per, 1'($urandom));
        else if (r < 55)
          push_cmd(KIND_RESET, 4'($urandom), base_sec, base_usec, per, 1'($urandom));
        else if (r < 82)
          push_cmd(KIND_TICK, 4'($urandom), base_sec, base_usec, per, 1'($urandom));
        else
          push_cmd(KIND_QUERY, 4'($urandom), base_sec, base_usec, per, 1'($urandom));
        // hold the sender until the table has answered everything
        if (n == 90) drain_all();
      end
      drain_all();
      burst_mode = 0;
    end

    if (mismatches == 0 && timer_events_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== multi_slot_timer_manager.f =====
+incdir+rtl
rtl/mstm_pkg.sv
rtl/mstm_cmd_if.sv
rtl/mstm_rsp_if.sv
rtl/mstm_cell.sv
rtl/mstm_div.sv
rtl/mstm_qry.sv
rtl/multi_slot_timer_manager.sv
sim/tb_multi_slot_timer_manager.sv
